>>> rtl/core/spcc_pkg.sv
// Package of shared types, constants and the size table function of the star projector.
package spcc_pkg;

    // Number of register stages from an accepted transaction to its result strobe.
    localparam int PIPE_DEPTH = 7;

    typedef enum logic [2:0] {
        CFG_AXIS_X       = 3'd0,
        CFG_AXIS_Y       = 3'd1,
        CFG_AXIS_Z       = 3'd2,
        CFG_COS_ANGLE    = 3'd3,
        CFG_SIN_ANGLE    = 3'd4,
        CFG_ZOOM         = 3'd5,
        CFG_MAG_LIMIT    = 3'd6,
        CFG_USE_ROTATION = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam t_rgb RGB_BLUE_WHITE = '{8'd200, 8'd220, 8'd255};
    localparam t_rgb RGB_WHITE      = '{8'd255, 8'd255, 8'd255};
    localparam t_rgb RGB_YELLOW     = '{8'd255, 8'd255, 8'd200};
    localparam t_rgb RGB_ORANGE     = '{8'd255, 8'd200, 8'd150};
    localparam t_rgb RGB_RED        = '{8'd255, 8'd150, 8'd150};
    localparam t_rgb RGB_PALE_BLUE  = '{8'd200, 8'd200, 8'd255};
    localparam t_rgb RGB_PINK       = '{8'd255, 8'd180, 8'd180};

    // Rotation setup handed to the rotator.
    typedef struct packed {
        logic signed [15:0] kx;
        logic signed [15:0] ky;
        logic signed [15:0] kz;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic               en;
    } t_rot_cfg;

    // Rotated position and hemisphere flag.
    typedef struct packed {
        logic signed [27:0] rx;
        logic signed [27:0] ry;
        logic               front;
    } t_rot_out;

    localparam int MAG_LOW   = -1024;
    localparam int MAG_HIGH  = 4095;
    localparam int MAG_SPAN  = 5120;
    localparam int SIZE_FLOOR = 102;

    localparam longint unsigned POW_STEPS [12] = '{
        64'd1071812012, 64'd1069885668, 64'd1066043361, 64'd1058400094,
        64'd1043277569, 64'd1013677647, 64'd956973408,  64'd852903448,
        64'd677485289,  64'd427464320,  64'd170176611,  64'd26971175
    };

    // Star size in Q8.8 at the start of bin i, evaluated at elaboration.
    function automatic logic [12:0] size_entry(input int i, input int Depth);
        longint          q;
        longint          e;
        longint unsigned p;
        longint unsigned s;
        q = longint'(MAG_LOW) + (longint'(i) * MAG_SPAN) / Depth;
        e = q + 1280;
        p = 64'd1 << 30;
        if (e > 2559) e = 2559;
        if (e < 0) e = 0;
        for (int b = 0; b < 12; b++) begin
            if (((e >> b) & 1) != 0) p = (p * POW_STEPS[b] + (64'd1 << 29)) >> 30;
        end
        s = (64'd30 * p + (64'd1 << 21)) >> 22;
        if (s < SIZE_FLOOR) s = SIZE_FLOOR;
        return s[12:0];
    endfunction

endpackage

>>> rtl/core/spcc_rotate.sv
// Five-stage Rodrigues rotator of a Q1.14 direction vector.
module spcc_rotate (
    input  logic                i_clk,
    input  logic signed [15:0]  i_vx,
    input  logic signed [15:0]  i_vy,
    input  logic signed [15:0]  i_vz,
    input  spcc_pkg::t_rot_cfg  i_cfg,
    output spcc_pkg::t_rot_out  o_rot
);

    // stage 1: plain products
    logic signed [31:0] r_kyvz, r_kzvy, r_kzvx, r_kxvz, r_kxvy, r_kyvx;
    logic signed [31:0] r_kxvx, r_kyvy, r_kzvz;
    logic signed [31:0] r_vc1 [3];
    // stage 2: cross and dot
    logic signed [32:0] r_cr2 [3];
    logic signed [20:0] r_kd2;
    logic signed [16:0] r_omc2;
    logic signed [31:0] r_vc2 [3];
    // stage 3
    logic signed [48:0] r_cs3 [3];
    logic signed [37:0] r_kdo3;
    logic signed [31:0] r_vc3 [3];
    // stage 4
    logic signed [48:0] r_cs4 [3];
    logic signed [53:0] r_kk4 [3];
    logic signed [31:0] r_vc4 [3];
    // vector bypass line
    logic signed [15:0] r_v [4][3];

    logic signed [34:0] w_dot;
    logic signed [55:0] w_f [3];
    logic signed [15:0] w_k [3];

    assign w_k[0] = i_cfg.kx;
    assign w_k[1] = i_cfg.ky;
    assign w_k[2] = i_cfg.kz;

    always_ff @(posedge i_clk) begin
        r_kyvz <= i_cfg.ky * i_vz;
        r_kzvy <= i_cfg.kz * i_vy;
        r_kzvx <= i_cfg.kz * i_vx;
        r_kxvz <= i_cfg.kx * i_vz;
        r_kxvy <= i_cfg.kx * i_vy;
        r_kyvx <= i_cfg.ky * i_vx;
        r_kxvx <= i_cfg.kx * i_vx;
        r_kyvy <= i_cfg.ky * i_vy;
        r_kzvz <= i_cfg.kz * i_vz;
        r_vc1[0] <= i_vx * i_cfg.c;
        r_vc1[1] <= i_vy * i_cfg.c;
        r_vc1[2] <= i_vz * i_cfg.c;
        r_v[0][0] <= i_vx;
        r_v[0][1] <= i_vy;
        r_v[0][2] <= i_vz;
    end

    assign w_dot = 35'(r_kxvx) + 35'(r_kyvy) + 35'(r_kzvz) + 35'sd8192;

    always_ff @(posedge i_clk) begin
        r_cr2[0] <= 33'(r_kyvz) - 33'(r_kzvy);
        r_cr2[1] <= 33'(r_kzvx) - 33'(r_kxvz);
        r_cr2[2] <= 33'(r_kxvy) - 33'(r_kyvx);
        r_kd2    <= 21'(w_dot >>> 14);
        r_omc2   <= 17'(18'sd16384 - 18'(i_cfg.c));
        r_kdo3   <= r_kd2 * r_omc2;
        for (int j = 0; j < 3; j++) begin
            r_vc2[j] <= r_vc1[j];
            r_cs3[j] <= r_cr2[j] * i_cfg.s;
            r_vc3[j] <= r_vc2[j];
            r_cs4[j] <= r_cs3[j];
            r_kk4[j] <= w_k[j] * r_kdo3;
            r_vc4[j] <= r_vc3[j];
        end
        for (int k = 1; k < 4; k++) begin
            r_v[k] <= r_v[k-1];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_f[j] = (56'(r_vc4[j]) <<< 14) + 56'(r_cs4[j]) + 56'(r_kk4[j]);
        end
    end

    // stage 5: round and select
    always_ff @(posedge i_clk) begin
        if (i_cfg.en) begin
            o_rot.rx    <= 28'((w_f[0] + 56'sd134217728) >>> 28);
            o_rot.ry    <= 28'((w_f[1] + 56'sd134217728) >>> 28);
            o_rot.front <= (w_f[2] > 56'sd0);
        end else begin
            o_rot.rx    <= 28'(r_v[3][0]);
            o_rot.ry    <= 28'(r_v[3][1]);
            o_rot.front <= (r_v[3][2] > 16'sd0);
        end
    end

endmodule

>>> rtl/core/spcc_size.sv
// Six-stage radius path: magnitude bin, size table and zoom scaling.
module spcc_size #(
    parameter int SIZE_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic signed [12:0] i_mag,
    input  logic [23:0]        i_zoom,
    output logic [15:0]        o_radius
);

    localparam int IW = $clog2(SIZE_TABLE_DEPTH);
    localparam int DW = $clog2(SIZE_TABLE_DEPTH + 1);
    // floor(y/75) = (y * RECIP_75) >> 36 for y below 2^28
    localparam longint unsigned RECIP_75 = 64'd916259690;

    logic [12:0]      r_u;
    logic [12:0]      r_n;
    logic [IW-1:0]    r_idx;
    logic [12:0]      r_entry;
    logic [27:0]      r_y;
    logic [12:0]      w_rom [SIZE_TABLE_DEPTH];
    logic [12:0]      w_u;
    logic [13+DW-1:0] w_ud;
    logic [28:0]      w_n5;
    logic [10:0]      w_q;
    logic [37:0]      w_x;
    logic [57:0]      w_yq;
    logic [21:0]      w_rad;

    for (genvar gi = 0; gi < SIZE_TABLE_DEPTH; gi++) begin : g_rom
        assign w_rom[gi] = spcc_pkg::size_entry(gi, SIZE_TABLE_DEPTH);
    end

    always_comb begin
        if (i_mag < 13'(spcc_pkg::MAG_LOW)) w_u = '0;
        else                                 w_u = 13'(i_mag + 13'sd1024);
    end

    assign w_ud = (13+DW)'(r_u) * (13+DW)'(SIZE_TABLE_DEPTH);
    assign w_n5 = 29'(r_n) * 29'd52429;
    assign w_q  = w_n5[28:18];
    assign w_x  = 38'(r_entry) * 38'(i_zoom) + 38'd38400;
    assign w_yq = 58'(r_y) * 58'(RECIP_75);
    assign w_rad = w_yq[57:36];

    always_ff @(posedge i_clk) begin
        r_u <= w_u;
        r_n <= 13'(w_ud >> 10);
        if (32'(w_q) >= SIZE_TABLE_DEPTH) r_idx <= IW'(SIZE_TABLE_DEPTH - 1);
        else                              r_idx <= IW'(w_q);
        r_entry <= w_rom[r_idx];
        r_y     <= w_x[37:10];
        if (w_rad > 22'd65535) o_radius <= 16'hFFFF;
        else                   o_radius <= w_rad[15:0];
    end

endmodule

>>> rtl/core/star_point_project_cull_color.sv
// Top level of the star projector: rotate, cull, place, size and color one star per cycle.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------------------------
//  star     | in        | i_start & !o_busy              | vec_x/y/z, magnitude, temp, B-V
//  result   | out       | o_valid, one cycle, no backoff | visible, screen x/y, radius, rgb
//  config   | in        | i_cfg_valid & o_cfg_ready      | i_cfg_index, i_cfg_data
//
// A star is taken every cycle; its result strobe comes out of the rotation
// multiply chain (products, cross/dot, scale, axis term, round), then projection
// and the cull/round stage. o_busy stays low and o_cfg_ready high.
// Reset clears the valid line and loads register defaults; nothing is lost to it
// beyond stars still in flight. The receiver cannot stall, so the pipe never holds.
module star_point_project_cull_color #(
    parameter int SCREEN_WIDTH     = 1200,
    parameter int SCREEN_HEIGHT    = 800,
    parameter int SIZE_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_vec_x,
    input  logic signed [15:0] i_vec_y,
    input  logic signed [15:0] i_vec_z,
    input  logic signed [12:0] i_magnitude,
    input  logic [15:0]        i_temperature,
    input  logic signed [10:0] i_color_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_visible,
    output logic signed [11:0] o_screen_x,
    output logic signed [11:0] o_screen_y,
    output logic [15:0]        o_radius,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    localparam int D = spcc_pkg::PIPE_DEPTH;
    localparam longint X_CENTER = longint'(SCREEN_WIDTH) * (64'sd1 <<< 21);
    localparam longint Y_CENTER = longint'(SCREEN_HEIGHT) * (64'sd1 <<< 21);
    localparam longint LO_EDGE  = -64'sd50 * (64'sd1 <<< 22);
    localparam longint X_EDGE   = longint'(SCREEN_WIDTH + 50) * (64'sd1 <<< 22);
    localparam longint Y_EDGE   = longint'(SCREEN_HEIGHT + 50) * (64'sd1 <<< 22);

    // configuration registers
    logic signed [15:0] r_axis_x, r_axis_y, r_axis_z, r_cos, r_sin;
    logic [23:0]        r_zoom;
    logic signed [12:0] r_mag_limit;
    logic               r_use_rot;

    // pipeline control and carried payload
    logic [D-1:0]       r_valid;
    logic [D-2:0]       r_bright;
    spcc_pkg::t_rgb     r_rgb [D-1];
    logic               r_front6;
    logic signed [53:0] r_px, r_py;

    spcc_pkg::t_rot_cfg w_rcfg;
    spcc_pkg::t_rot_out w_rot;
    spcc_pkg::t_rgb     n_rgb;
    logic [15:0]        w_radius;
    logic signed [24:0] w_zs;
    logic signed [52:0] w_zx, w_zy;
    logic signed [53:0] w_sx, w_sy;
    logic               w_show;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // take configuration writes; drop writes to an index beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_x    <= '0;
            r_axis_y    <= '0;
            r_axis_z    <= 16'sd16384;
            r_cos       <= 16'sd16384;
            r_sin       <= '0;
            r_zoom      <= 24'd76800;
            r_mag_limit <= 13'sd2304;
            r_use_rot   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready && !i_cfg_index[3]) begin
            unique case (spcc_pkg::t_cfg_idx'(i_cfg_index[2:0]))
                spcc_pkg::CFG_AXIS_X:       r_axis_x    <= i_cfg_data[15:0];
                spcc_pkg::CFG_AXIS_Y:       r_axis_y    <= i_cfg_data[15:0];
                spcc_pkg::CFG_AXIS_Z:       r_axis_z    <= i_cfg_data[15:0];
                spcc_pkg::CFG_COS_ANGLE:    r_cos       <= i_cfg_data[15:0];
                spcc_pkg::CFG_SIN_ANGLE:    r_sin       <= i_cfg_data[15:0];
                spcc_pkg::CFG_ZOOM:         r_zoom      <= i_cfg_data;
                spcc_pkg::CFG_MAG_LIMIT:    r_mag_limit <= i_cfg_data[12:0];
                spcc_pkg::CFG_USE_ROTATION: r_use_rot   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_rcfg = '{kx: r_axis_x, ky: r_axis_y, kz: r_axis_z,
                      c: r_cos, s: r_sin, en: r_use_rot};

    spcc_rotate u_rotate (
        .i_clk (i_clk),
        .i_vx  (i_vec_x),
        .i_vy  (i_vec_y),
        .i_vz  (i_vec_z),
        .i_cfg (w_rcfg),
        .o_rot (w_rot)
    );

    spcc_size #(
        .SIZE_TABLE_DEPTH (SIZE_TABLE_DEPTH)
    ) u_size (
        .i_clk    (i_clk),
        .i_mag    (i_magnitude),
        .i_zoom   (r_zoom),
        .o_radius (w_radius)
    );

    // pick color by temperature, else B-V, else magnitude
    always_comb begin
        if (i_temperature != 16'd0) begin
            priority if (i_temperature >= 16'd32500) n_rgb = spcc_pkg::RGB_BLUE_WHITE;
            else if (i_temperature >= 16'd25000)     n_rgb = spcc_pkg::RGB_WHITE;
            else if (i_temperature >= 16'd17500)     n_rgb = spcc_pkg::RGB_YELLOW;
            else if (i_temperature >= 16'd10000)     n_rgb = spcc_pkg::RGB_ORANGE;
            else                                     n_rgb = spcc_pkg::RGB_RED;
        end else if (i_color_index != 11'sd0) begin
            priority if (i_color_index < 11'sd0)     n_rgb = spcc_pkg::RGB_BLUE_WHITE;
            else if (i_color_index < 11'sd128)       n_rgb = spcc_pkg::RGB_WHITE;
            else if (i_color_index < 11'sd256)       n_rgb = spcc_pkg::RGB_YELLOW;
            else if (i_color_index < 11'sd384)       n_rgb = spcc_pkg::RGB_ORANGE;
            else                                     n_rgb = spcc_pkg::RGB_RED;
        end else begin
            priority if (i_magnitude <= 13'sd512)    n_rgb = spcc_pkg::RGB_WHITE;
            else if (i_magnitude <= 13'sd1024)       n_rgb = spcc_pkg::RGB_PALE_BLUE;
            else if (i_magnitude <= 13'sd1536)       n_rgb = spcc_pkg::RGB_YELLOW;
            else                                     n_rgb = spcc_pkg::RGB_PINK;
        end
    end

    // advance the valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[D-2:0], i_start & ~o_busy};
        end
    end

    // carry brightness test and color alongside the arithmetic
    always_ff @(posedge i_clk) begin
        r_bright[0] <= (i_magnitude <= r_mag_limit);
        r_rgb[0]    <= n_rgb;
        for (int k = 1; k < D - 1; k++) begin
            r_bright[k] <= r_bright[k-1];
            r_rgb[k]    <= r_rgb[k-1];
        end
    end

    // stage 6: orthographic projection in Q22
    assign w_zs = signed'({1'b0, r_zoom});
    assign w_zx = w_rot.rx * w_zs;
    assign w_zy = w_rot.ry * w_zs;

    always_ff @(posedge i_clk) begin
        r_px     <= 54'(X_CENTER) + 54'(w_zx);
        r_py     <= 54'(Y_CENTER) - 54'(w_zy);
        r_front6 <= w_rot.front;
    end

    // stage 7: cull, round to pixels, drop fields of hidden stars
    assign w_show = r_bright[D-2] && r_front6 &&
                    !(r_px < 54'(LO_EDGE)) && !(r_px > 54'(X_EDGE)) &&
                    !(r_py < 54'(LO_EDGE)) && !(r_py > 54'(Y_EDGE));
    assign w_sx = (r_px + 54'sd2097152) >>> 22;
    assign w_sy = (r_py + 54'sd2097152) >>> 22;

    always_ff @(posedge i_clk) begin
        o_visible  <= w_show;
        o_screen_x <= w_show ? w_sx[11:0] : '0;
        o_screen_y <= w_show ? w_sy[11:0] : '0;
        o_radius   <= w_show ? w_radius : '0;
        o_red      <= w_show ? r_rgb[D-2].red : '0;
        o_green    <= w_show ? r_rgb[D-2].green : '0;
        o_blue     <= w_show ? r_rgb[D-2].blue : '0;
    end

    assign o_valid = r_valid[D-1];

endmodule

>>> rtl/core/spcc_checker.sv
// Port-level checker of the star projector and its bind.
module spcc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input logic               o_visible,
    input logic signed [11:0] o_screen_x,
    input logic signed [11:0] o_screen_y,
    input logic [15:0]        o_radius,
    input logic [7:0]         o_red,
    input logic [7:0]         o_green,
    input logic [7:0]         o_blue
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##7 o_valid)
        else $error("result missing after accepted transaction");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 7))
        else $error("result without transaction");

    a_culled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_screen_x == 12'sd0 && o_screen_y == 12'sd0 &&
        o_radius == 16'd0 && o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("culled star carries data");

endmodule

bind star_point_project_cull_color spcc_checker u_spcc_checker (.*);

>>> test/star_point_project_cull_color_test.sv
// Testbench for the star projector: directed table, random config phases, self-checking.
`timescale 1ns / 100ps

module star_point_project_cull_color_test;

    localparam int SCR_W     = 1200;
    localparam int SCR_H     = 800;
    localparam int TBL_DEPTH = 256;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_STARS = 50;

    // One star as presented on the input ports.
    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [12:0] mag;
        logic [15:0]        temp;
        logic signed [10:0] bv;
    } t_star;

    // One projected star as it leaves the block.
    typedef struct {
        logic           visible;
        logic [11:0]    sx;
        logic [11:0]    sy;
        logic [15:0]    radius;
        spcc_pkg::t_rgb rgb;
    } t_proj;

    // Directed row: expectation typed in only when it is obvious.
    typedef struct {
        t_star st;
        bit    typed;
        t_proj res;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [15:0] i_vec_x;
    logic signed [15:0] i_vec_y;
    logic signed [15:0] i_vec_z;
    logic signed [12:0] i_magnitude;
    logic [15:0]        i_temperature;
    logic signed [10:0] i_color_index;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               o_valid;
    logic               o_visible;
    logic signed [11:0] o_screen_x;
    logic signed [11:0] o_screen_y;
    logic [15:0]        o_radius;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;

    star_point_project_cull_color #(
        .SCREEN_WIDTH    (SCR_W),
        .SCREEN_HEIGHT   (SCR_H),
        .SIZE_TABLE_DEPTH(TBL_DEPTH)
    ) u_dut (.*);

    // Shadow copy of the block's registers.
    logic signed [15:0] sh_kx, sh_ky, sh_kz, sh_cos, sh_sin;
    logic [23:0]        sh_zoom;
    logic signed [12:0] sh_mag_limit;
    logic               sh_rotate;

    longint unsigned size_q88 [TBL_DEPTH];
    t_proj           pending_proj[$];
    t_row            rows[$];
    int              mismatches;

    // Q30 approximations of 10^(-2^b/1280).
    localparam longint unsigned DECADE_STEP [12] = '{
        64'd1071812012, 64'd1069885668, 64'd1066043361, 64'd1058400094,
        64'd1043277569, 64'd1013677647, 64'd956973408,  64'd852903448,
        64'd677485289,  64'd427464320,  64'd170176611,  64'd26971175
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Round half up, then shift right arithmetically.
    function automatic longint round_shr(input longint x, input int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // Build the magnitude-to-size table in Q8.8.
    function automatic void build_size_table();
        longint          q, e;
        longint unsigned p, s;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            q = -1024 + (longint'(i) * 5120) / TBL_DEPTH;
            e = q + 1280;
            if (e > 2559) e = 2559;
            if (e < 0) e = 0;
            p = 64'd1 << 30;
            for (int b = 0; b < 12; b++) begin
                if (e[b]) p = (p * DECADE_STEP[b] + (64'd1 << 29)) >> 30;
            end
            s = (64'd30 * p + (64'd1 << 21)) >> 22;
            size_q88[i] = (s < 102) ? 64'd102 : s;
        end
    endfunction

    // Rotate, cull, place, size and color one star under the shadow registers.
    function automatic t_proj project_star(input t_star st);
        t_proj           r;
        longint          vx, vy, vz, kx, ky, kz, c, s, kd, omc;
        longint          rx, ry, rz, px, py, mq, zm;
        longint unsigned idx, rad;
        longint unsigned t;
        r = '{default: '0};
        vx = longint'(st.vx); vy = longint'(st.vy); vz = longint'(st.vz);
        zm = longint'(sh_zoom);
        if (longint'(st.mag) > longint'(sh_mag_limit)) return r;
        rx = vx; ry = vy; rz = vz;
        if (sh_rotate) begin
            kx = longint'(sh_kx); ky = longint'(sh_ky); kz = longint'(sh_kz);
            c = longint'(sh_cos); s = longint'(sh_sin);
            kd  = round_shr(kx * vx + ky * vy + kz * vz, 14);
            omc = 16384 - c;
            rx = round_shr(vx * c * 16384 + (ky * vz - kz * vy) * s + kx * kd * omc, 28);
            ry = round_shr(vy * c * 16384 + (kz * vx - kx * vz) * s + ky * kd * omc, 28);
            rz = vz * c * 16384 + (kx * vy - ky * vx) * s + kz * kd * omc;
        end
        if (rz <= 0) return r;
        px = longint'(SCR_W) * (longint'(1) <<< 21) + rx * zm;
        py = longint'(SCR_H) * (longint'(1) <<< 21) - ry * zm;
        // drop stars more than 50 pixels off screen
        if (px < -50 * (longint'(1) <<< 22) || px > (SCR_W + 50) * (longint'(1) <<< 22) ||
            py < -50 * (longint'(1) <<< 22) || py > (SCR_H + 50) * (longint'(1) <<< 22))
            return r;
        mq = longint'(st.mag);
        if (mq < -1024) mq = -1024;
        if (mq > 4095) mq = 4095;
        idx = ((mq + 1024) * TBL_DEPTH) / 5120;
        if (idx >= TBL_DEPTH) idx = TBL_DEPTH - 1;
        rad = (size_q88[idx] * longint'(sh_zoom) + 38400) / 76800;
        if (rad > 65535) rad = 65535;
        r.visible = 1'b1;
        r.sx      = 12'(round_shr(px, 22));
        r.sy      = 12'(round_shr(py, 22));
        r.radius  = rad[15:0];
        // color by temperature first, then B-V, then magnitude
        if (st.temp != 0) begin
            t = 64'(st.temp);
            if (t < 2500) t = 2500;
            if (t > 40000) t = 40000;
            if (t >= 32500)      r.rgb = spcc_pkg::RGB_BLUE_WHITE;
            else if (t >= 25000) r.rgb = spcc_pkg::RGB_WHITE;
            else if (t >= 17500) r.rgb = spcc_pkg::RGB_YELLOW;
            else if (t >= 10000) r.rgb = spcc_pkg::RGB_ORANGE;
            else                 r.rgb = spcc_pkg::RGB_RED;
        end else if (st.bv != 0) begin
            if (st.bv < 0)        r.rgb = spcc_pkg::RGB_BLUE_WHITE;
            else if (st.bv < 128) r.rgb = spcc_pkg::RGB_WHITE;
            else if (st.bv < 256) r.rgb = spcc_pkg::RGB_YELLOW;
            else if (st.bv < 384) r.rgb = spcc_pkg::RGB_ORANGE;
            else                  r.rgb = spcc_pkg::RGB_RED;
        end else begin
            if (st.mag <= 512)       r.rgb = spcc_pkg::RGB_WHITE;
            else if (st.mag <= 1024) r.rgb = spcc_pkg::RGB_PALE_BLUE;
            else if (st.mag <= 1536) r.rgb = spcc_pkg::RGB_YELLOW;
            else                     r.rgb = spcc_pkg::RGB_PINK;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // Check every result strobe against the oldest pending projection.
    always @(posedge i_clk) begin
        t_proj want;
        if (i_rst_n && o_valid) begin
            if (pending_proj.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_proj.pop_front();
                if (o_visible !== want.visible)
                    report_mismatch("visible", o_visible, want.visible);
                if (o_screen_x !== want.sx) report_mismatch("screen_x", o_screen_x, want.sx);
                if (o_screen_y !== want.sy) report_mismatch("screen_y", o_screen_y, want.sy);
                if (o_radius !== want.radius) report_mismatch("radius", o_radius, want.radius);
                if (o_red !== want.rgb.red) report_mismatch("red", o_red, want.rgb.red);
                if (o_green !== want.rgb.green)
                    report_mismatch("green", o_green, want.rgb.green);
                if (o_blue !== want.rgb.blue) report_mismatch("blue", o_blue, want.rgb.blue);
            end
        end
    end

    // Write one register and mirror it in the shadow copy; the caller drops valid.
    task automatic write_reg(input spcc_pkg::t_cfg_idx idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= {1'b0, idx};
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            spcc_pkg::CFG_AXIS_X:       sh_kx = data[15:0];
            spcc_pkg::CFG_AXIS_Y:       sh_ky = data[15:0];
            spcc_pkg::CFG_AXIS_Z:       sh_kz = data[15:0];
            spcc_pkg::CFG_COS_ANGLE:    sh_cos = data[15:0];
            spcc_pkg::CFG_SIN_ANGLE:    sh_sin = data[15:0];
            spcc_pkg::CFG_ZOOM:         sh_zoom = data;
            spcc_pkg::CFG_MAG_LIMIT:    sh_mag_limit = data[12:0];
            spcc_pkg::CFG_USE_ROTATION: sh_rotate = data[0];
        endcase
    endtask

    // Hold off until every pending projection has come back and the pipe is empty.
    task automatic drain_pipe();
        while (pending_proj.size() != 0) @(posedge i_clk);
        repeat (spcc_pkg::PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Present one star after a random gap; predict it once accepted.
    task automatic send_star(input t_star st, input bit typed, input t_proj typed_res);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_vec_x       <= st.vx;
        i_vec_y       <= st.vy;
        i_vec_z       <= st.vz;
        i_magnitude   <= st.mag;
        i_temperature <= st.temp;
        i_color_index <= st.bv;
        do @(posedge i_clk); while (o_busy);
        pending_proj.push_back(typed ? typed_res : project_star(st));
    endtask

    function automatic logic [15:0] q14(input real v);
        return 16'($rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5)));
    endfunction

    // Random star: mostly unit directions with sensible fields, some raw bits.
    function automatic t_star random_star();
        t_star st;
        real   z, th, rho;
        if ($urandom_range(0, 9) < 7) begin
            z   = $urandom_range(0, 20000) / 10000.0 - 0.6;
            if (z > 1.0) z = 1.0;
            th  = $urandom_range(0, 62831) / 10000.0;
            rho = $sqrt(1.0 - z * z);
            st.vx = q14(rho * $cos(th));
            st.vy = q14(rho * $sin(th));
            st.vz = q14(z);
        end else begin
            st.vx = 16'($urandom);
            st.vy = 16'($urandom);
            st.vz = 16'($urandom);
        end
        st.mag  = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 3072));
        st.temp = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        st.bv   = ($urandom_range(0, 2) == 0) ? 11'd0 : 11'($urandom);
        return st;
    endfunction

    // Load one register setting per phase, the extremes among them.
    task automatic load_phase(input int ph);
        real ax, ay, az, nrm, ang;
        ax = $urandom_range(0, 20000) / 10000.0 - 1.0;
        ay = $urandom_range(0, 20000) / 10000.0 - 1.0;
        az = $urandom_range(0, 20000) / 10000.0 - 1.0;
        nrm = $sqrt(ax * ax + ay * ay + az * az) + 1.0e-6;
        ang = $urandom_range(0, 12000) / 10000.0;
        case (ph)
            0: begin
                // extremes: smallest nonzero zoom, widest magnitude window, half turn
                write_reg(spcc_pkg::CFG_AXIS_X, 24'h004000);
                write_reg(spcc_pkg::CFG_AXIS_Y, 24'h000000);
                write_reg(spcc_pkg::CFG_AXIS_Z, 24'h000000);
                write_reg(spcc_pkg::CFG_COS_ANGLE, 24'h00C000);
                write_reg(spcc_pkg::CFG_SIN_ANGLE, 24'h000000);
                write_reg(spcc_pkg::CFG_ZOOM, 24'd1);
                write_reg(spcc_pkg::CFG_MAG_LIMIT, 24'h000FFF);
                write_reg(spcc_pkg::CFG_USE_ROTATION, 24'd1);
            end
            1: begin
                // extremes: largest zoom, brightest limit
                write_reg(spcc_pkg::CFG_ZOOM, 24'hFFFFFF);
                write_reg(spcc_pkg::CFG_MAG_LIMIT, 24'h001C00);
                write_reg(spcc_pkg::CFG_USE_ROTATION, 24'd0);
            end
            2: begin
                // every register bit raw but the rotation enable
                write_reg(spcc_pkg::CFG_AXIS_X, 24'($urandom));
                write_reg(spcc_pkg::CFG_AXIS_Y, 24'($urandom));
                write_reg(spcc_pkg::CFG_AXIS_Z, 24'($urandom));
                write_reg(spcc_pkg::CFG_COS_ANGLE, 24'($urandom));
                write_reg(spcc_pkg::CFG_SIN_ANGLE, 24'($urandom));
                write_reg(spcc_pkg::CFG_ZOOM, 24'($urandom));
                write_reg(spcc_pkg::CFG_MAG_LIMIT, 24'($urandom));
                write_reg(spcc_pkg::CFG_USE_ROTATION, 24'd1);
            end
            3: begin
                // zoom of zero: everything at the screen center
                write_reg(spcc_pkg::CFG_ZOOM, 24'd0);
                write_reg(spcc_pkg::CFG_USE_ROTATION, 24'd0);
                write_reg(spcc_pkg::CFG_MAG_LIMIT, 24'h000FFF);
            end
            default: begin
                // well-formed view: unit axis, small angle, moderate zoom
                write_reg(spcc_pkg::CFG_AXIS_X, 24'(q14(ax / nrm)));
                write_reg(spcc_pkg::CFG_AXIS_Y, 24'(q14(ay / nrm)));
                write_reg(spcc_pkg::CFG_AXIS_Z, 24'(q14(az / nrm)));
                write_reg(spcc_pkg::CFG_COS_ANGLE, 24'(q14($cos(ang))));
                write_reg(spcc_pkg::CFG_SIN_ANGLE, 24'(q14($sin(ang))));
                write_reg(spcc_pkg::CFG_ZOOM, 24'($urandom_range(256, 1200000)));
                write_reg(spcc_pkg::CFG_MAG_LIMIT, 24'($urandom_range(1024, 4095)));
                write_reg(spcc_pkg::CFG_USE_ROTATION, 24'($urandom_range(0, 1)));
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(input logic [15:0] vx, vy, vz, input logic [12:0] mag,
                                    input logic [15:0] temp, input logic [10:0] bv,
                                    input bit culled);
        t_row rw;
        rw.st    = '{vx, vy, vz, mag, temp, bv};
        rw.typed = culled;
        rw.res   = '{default: '0};
        rows.push_back(rw);
    endfunction

    initial begin
        t_proj none;
        none = '{default: '0};
        mismatches    = 0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_vec_x       = '0;
        i_vec_y       = '0;
        i_vec_z       = '0;
        i_magnitude   = '0;
        i_temperature = '0;
        i_color_index = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        sh_kx = 0; sh_ky = 0; sh_kz = 16384; sh_cos = 16384; sh_sin = 0;
        sh_zoom = 24'd76800; sh_mag_limit = 13'sd2304; sh_rotate = 1'b0;
        build_size_table();

        // directed: culls, field extremes, every temperature and B-V color band and edges
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0FFF, 16'd0, 11'd0, 1'b1);   // too faint
        add_row(16'h0000, 16'h0000, 16'hC000, 13'h0000, 16'd0, 11'd0, 1'b1);   // far side
        add_row(16'h4000, 16'h0000, 16'h0000, 13'h0000, 16'd0, 11'd0, 1'b1);   // z at zero
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h1C00, 16'd0, 11'd0, 1'b0);
        add_row(16'h4000, 16'hC000, 16'h0001, 13'h0900, 16'hFFFF, 11'd0, 1'b0);
        add_row(16'hC000, 16'h4000, 16'h7FFF, 13'h0200, 16'd1, 11'd0, 1'b0);
        add_row(16'h8000, 16'h7FFF, 16'h2000, 13'h0201, 16'd9999, 11'd0, 1'b0);
        add_row(16'h2000, 16'h2000, 16'h2D41, 13'h0400, 16'd10000, 11'd0, 1'b0);
        add_row(16'hE000, 16'h1000, 16'h3000, 13'h0401, 16'd17500, 11'd0, 1'b0);
        add_row(16'h0100, 16'hFF00, 16'h3F00, 13'h0600, 16'd25000, 11'd0, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0601, 16'd32500, 11'd0, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd40000, 11'd0, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'h400, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'h7FF, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'd127, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'd128, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'd255, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'd256, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'd383, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd0, 11'h3FF, 1'b0);
        add_row(16'h0000, 16'h0000, 16'h4000, 13'h0000, 16'd2499, 11'd5, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) send_star(rows[n].st, rows[n].typed, rows[n].res);
        i_start <= 1'b0;

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_pipe();
            load_phase(ph);
            for (int k = 0; k < PHASE_STARS; k++) begin
                send_star(random_star(), 1'b0, none);
                // let the whole pipe empty once mid-run
                if (ph == 4 && k == PHASE_STARS / 2) begin
                    i_start <= 1'b0;
                    while (pending_proj.size() != 0) @(posedge i_clk);
                end
                // run back-to-back stretches with no gaps through the gap draw alone
            end
            i_start <= 1'b0;
        end

        drain_pipe();
        if (mismatches == 0 && pending_proj.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Give up if the run stalls.
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/spcc_pkg.sv
rtl/core/spcc_rotate.sv
rtl/core/spcc_size.sv
rtl/core/star_point_project_cull_color.sv
rtl/core/spcc_checker.sv
test/star_point_project_cull_color_test.sv
